@@ hdl/rlh_pkg.sv @@
// Shared types, op codes and the luminance bin function for the RGB/luma histogram.
// No dependencies; used by rgb_luminance_histogram.
package rlh_pkg;

  localparam int COUNT_WIDTH = 32;
  localparam int NUM_BINS    = 256;
  localparam int BIN_W       = 8;
  localparam int NUM_HIST    = 4;

  localparam logic [1:0] OP_ACCUM = 2'd0;
  localparam logic [1:0] OP_READ  = 2'd1;
  localparam logic [1:0] OP_CLEAR = 2'd2;

  localparam logic [1:0] CH_RED   = 2'd0;
  localparam logic [1:0] CH_GREEN = 2'd1;
  localparam logic [1:0] CH_BLUE  = 2'd2;
  localparam logic [1:0] CH_LUMA  = 2'd3;

  localparam logic [7:0] W_RED   = 8'd54;
  localparam logic [7:0] W_GREEN = 8'd183;
  localparam logic [7:0] W_BLUE  = 8'd19;

  typedef struct packed {
    logic [1:0] op;
    logic [7:0] red;
    logic [7:0] green;
    logic [7:0] blue;
    logic [1:0] channel;
    logic [7:0] bin_index;
  } in_item_t;

  typedef struct packed {
    logic [31:0] bin_count;
    logic [31:0] pixel_total;
  } out_item_t;

  // Weights sum to 256, so the rounded sum fits 16 bits and the bin in 8.
  function automatic logic [BIN_W-1:0] luma_bin(input logic [7:0] r, input logic [7:0] g,
                                                input logic [7:0] b);
    logic [15:0] sum;
    sum = 16'(r) * 16'(W_RED) + 16'(g) * 16'(W_GREEN) + 16'(b) * 16'(W_BLUE) + 16'd128;
    return sum[15:8];
  endfunction

endpackage

@@ hdl/rgb_luminance_histogram.sv @@
// Top level of the RGB and luminance histogram: four bin memories, clearing pass, pixel counter.
// Depends on rlh_pkg for the payload structs, op codes and luminance bin function.

// Each transaction is first accepted, which reads the four bin memories (one synchronous
// read per memory) and sets busy_r; in the busy state it increments and writes back, or
// forms a read result, or starts a clear. Input is stalled while busy, so no new item is
// accepted before the last one is done. A read result sits in an output register; the block
// keeps accepting items while it waits, and stalls only when a second read result would
// have nowhere to go. A clear zeroes the pixel counter in its busy state and then writes
// zero into all 256 addresses of the four bin memories one address per cycle, with input
// stalled until that sweep ends; the same pass runs right after reset before the first item
// is taken. Counts saturate at COUNT_WIDTH bits and are clamped to 32 bits on output.
module rgb_luminance_histogram #(
  parameter int COUNT_WIDTH = rlh_pkg::COUNT_WIDTH
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_stall,
  input  rlh_pkg::in_item_t in_data,
  output logic              out_valid,
  input  logic              out_stall,
  output rlh_pkg::out_item_t out_data
);

  localparam int NB = rlh_pkg::NUM_BINS;
  localparam int NH = rlh_pkg::NUM_HIST;
  localparam int AW = rlh_pkg::BIN_W;

  logic                   in_acc;
  logic                   busy_r;
  logic                   stage_done;
  logic [1:0]             op_r;
  logic [1:0]             chan_r;
  logic [AW-1:0]          addr_r   [NH];
  logic [AW-1:0]          rd_addr  [NH];
  logic [COUNT_WIDTH-1:0] rd_data_r[NH];
  logic [COUNT_WIDTH-1:0] wr_data  [NH];
  logic                   wr_en;
  logic                   start_clr;
  logic                   clr_r;
  logic [AW-1:0]          clr_addr_r;
  logic [COUNT_WIDTH-1:0] pixels_r;
  logic                   out_valid_r;
  rlh_pkg::out_item_t     out_data_r;
  logic [AW-1:0]          luma;
  logic [COUNT_WIDTH-1:0] sel_count;
  logic                   load_out;
  logic [31:0]            count_clamped;
  logic [31:0]            total_clamped;

  assign in_stall   = busy_r | clr_r;
  assign in_acc     = in_valid & ~in_stall;
  assign luma       = rlh_pkg::luma_bin(in_data.red, in_data.green, in_data.blue);

  // Reads address every memory at the bin index; accumulates at the pixel's own bins.
  always_comb begin
    if (in_data.op == rlh_pkg::OP_READ) begin
      rd_addr[rlh_pkg::CH_RED]   = in_data.bin_index;
      rd_addr[rlh_pkg::CH_GREEN] = in_data.bin_index;
      rd_addr[rlh_pkg::CH_BLUE]  = in_data.bin_index;
      rd_addr[rlh_pkg::CH_LUMA]  = in_data.bin_index;
    end else begin
      rd_addr[rlh_pkg::CH_RED]   = in_data.red;
      rd_addr[rlh_pkg::CH_GREEN] = in_data.green;
      rd_addr[rlh_pkg::CH_BLUE]  = in_data.blue;
      rd_addr[rlh_pkg::CH_LUMA]  = luma;
    end
  end

  assign wr_en     = busy_r && (op_r == rlh_pkg::OP_ACCUM);
  assign start_clr = busy_r && (op_r == rlh_pkg::OP_CLEAR);

  genvar g;
  generate
    for (g = 0; g < NH; g++) begin : g_hist
      logic [COUNT_WIDTH-1:0] mem [NB];

      // Saturate at all ones.
      assign wr_data[g] = (&rd_data_r[g]) ? rd_data_r[g] : rd_data_r[g] + COUNT_WIDTH'(1);

      always_ff @(posedge clk) begin
        if (in_acc) begin
          rd_data_r[g] <= mem[rd_addr[g]];
        end
        if (clr_r) begin
          mem[clr_addr_r] <= '0;
        end else if (wr_en) begin
          mem[addr_r[g]] <= wr_data[g];
        end
      end
    end
  endgenerate

  // Sweep every address once after reset and after each clear.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      clr_r      <= 1'b1;
      clr_addr_r <= '0;
    end else if (start_clr) begin
      clr_r      <= 1'b1;
      clr_addr_r <= '0;
    end else if (clr_r) begin
      clr_addr_r <= clr_addr_r + AW'(1);
      if (clr_addr_r == AW'(NB - 1)) begin
        clr_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pixels_r <= '0;
    end else if (start_clr) begin
      pixels_r <= '0;
    end else if (wr_en && !(&pixels_r)) begin
      pixels_r <= pixels_r + COUNT_WIDTH'(1);
    end
  end

  // Read result path: pick the channel, clamp to 32 bits.
  assign sel_count     = rd_data_r[chan_r];
  assign count_clamped = (64'(sel_count) > 64'hFFFF_FFFF) ? 32'hFFFF_FFFF : 32'(sel_count);
  assign total_clamped = (64'(pixels_r) > 64'hFFFF_FFFF) ? 32'hFFFF_FFFF : 32'(pixels_r);

  // Hold a read in the busy state until the output register frees up.
  assign load_out   = busy_r && (op_r == rlh_pkg::OP_READ) && (!out_valid_r || !out_stall);
  assign stage_done = !(busy_r && (op_r == rlh_pkg::OP_READ)) || load_out;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
    end else if (in_acc) begin
      busy_r <= 1'b1;
    end else if (stage_done) begin
      busy_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc) begin
      op_r   <= in_data.op;
      chan_r <= in_data.channel;
      for (int h = 0; h < NH; h++) begin
        addr_r[h] <= rd_addr[h];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (load_out) begin
      out_valid_r <= 1'b1;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load_out) begin
      out_data_r.bin_count   <= count_clamped;
      out_data_r.pixel_total <= total_clamped;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  // A new result appears only after a read was held in its busy state.
  a_result_from_read : assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> $past(busy_r && op_r == rlh_pkg::OP_READ))
    else $error("result without a read");

  // A clear leaves the pixel counter at zero.
  a_clear_zeroes : assert property (@(posedge clk) disable iff (!rst_n)
    (busy_r && op_r == rlh_pkg::OP_CLEAR) |=> (pixels_r == '0))
    else $error("pixel counter not cleared");

  // An accumulate never lowers the pixel counter and leaves it nonzero.
  a_pixel_grows : assert property (@(posedge clk) disable iff (!rst_n)
    wr_en |=> (pixels_r >= $past(pixels_r)) && (pixels_r != '0))
    else $error("pixel counter went backward");

endmodule

@@ verif/rgb_luminance_histogram_tb.sv @@
// Self-checking bench for rgb_luminance_histogram: directed rows, then random pixel streams.
// Uses rlh_pkg for the payload structs, op codes, channel codes and luminance weights.
module rgb_luminance_histogram_tb;
  import rlh_pkg::*;

  localparam logic [1:0]  OP_UNUSED  = 2'd3;
  localparam logic [31:0] COUNT_MAX  = 32'hFFFF_FFFF;
  localparam int          HOLD_LEN   = 80;
  localparam int          QUIET_MAX  = 2000;
  localparam int          DRAIN_WAIT = 8;
  localparam int          PHASE_LEN  = 95;

  typedef struct packed {
    in_item_t  item;
    logic      typed;
    out_item_t want;
  } plan_row_t;

  logic      clk = 1'b0;
  logic      rst_n = 1'b0;
  logic      in_valid = 1'b0;
  logic      in_stall;
  in_item_t  in_data = '0;
  logic      out_valid;
  logic      out_stall = 1'b0;
  out_item_t out_data;

  rgb_luminance_histogram dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .in_data  (in_data),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .out_data (out_data)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  // Histogram mirror
  logic [31:0] red_cnt   [NUM_BINS];
  logic [31:0] green_cnt [NUM_BINS];
  logic [31:0] blue_cnt  [NUM_BINS];
  logic [31:0] luma_cnt  [NUM_BINS];
  logic [3:0]  bin_seen  [NUM_BINS];
  logic [31:0] pixel_cnt;
  logic [7:0]  last_red, last_green, last_blue, last_luma;

  out_item_t pending_bin_reads[$];
  plan_row_t directed_rows[$];

  int send_idle_pct = 0;
  int recv_stall_pct = 0;
  int hold_req = 0;
  int hold_ack = 0;
  int hold_left = 0;
  int transactions_sent = 0;
  int results_checked = 0;
  int clears_seen = 0;
  int failures = 0;
  int quiet_cycles = 0;
  out_item_t seen_want;

  function automatic logic [7:0] luma_index(input logic [7:0] r, input logic [7:0] g,
                                            input logic [7:0] b);
    int unsigned weighted;
    weighted = int'(W_RED) * int'(r) + int'(W_GREEN) * int'(g) + int'(W_BLUE) * int'(b) + 128;
    return 8'(weighted >> 8);
  endfunction

  function automatic logic [31:0] bumped(input logic [31:0] v, input logic seen);
    if (!seen) return 32'd1;
    return (v == COUNT_MAX) ? v : v + 32'd1;
  endfunction

  task automatic apply_to_histograms(input in_item_t it, output bit makes_result,
                                     output out_item_t res);
    logic [7:0] lbin;
    logic       hit;
    makes_result = 1'b0;
    res = '0;
    case (it.op)
      OP_ACCUM: begin
        lbin = luma_index(it.red, it.green, it.blue);
        red_cnt[it.red]     = bumped(red_cnt[it.red], bin_seen[it.red][CH_RED]);
        green_cnt[it.green] = bumped(green_cnt[it.green], bin_seen[it.green][CH_GREEN]);
        blue_cnt[it.blue]   = bumped(blue_cnt[it.blue], bin_seen[it.blue][CH_BLUE]);
        luma_cnt[lbin]      = bumped(luma_cnt[lbin], bin_seen[lbin][CH_LUMA]);
        bin_seen[it.red][CH_RED]     = 1'b1;
        bin_seen[it.green][CH_GREEN] = 1'b1;
        bin_seen[it.blue][CH_BLUE]   = 1'b1;
        bin_seen[lbin][CH_LUMA]      = 1'b1;
        pixel_cnt = (pixel_cnt == COUNT_MAX) ? pixel_cnt : pixel_cnt + 32'd1;
        last_red   = it.red;
        last_green = it.green;
        last_blue  = it.blue;
        last_luma  = lbin;
      end
      OP_READ: begin
        makes_result = 1'b1;
        hit = bin_seen[it.bin_index][it.channel];
        case (it.channel)
          CH_RED:   res.bin_count = hit ? red_cnt[it.bin_index] : '0;
          CH_GREEN: res.bin_count = hit ? green_cnt[it.bin_index] : '0;
          CH_BLUE:  res.bin_count = hit ? blue_cnt[it.bin_index] : '0;
          default:  res.bin_count = hit ? luma_cnt[it.bin_index] : '0;
        endcase
        res.pixel_total = pixel_cnt;
      end
      OP_CLEAR: begin
        foreach (bin_seen[i]) bin_seen[i] = '0;
        pixel_cnt = '0;
        clears_seen++;
      end
      default: ;
    endcase
  endtask

  function automatic in_item_t random_item();
    in_item_t it;
    int       pick;
    it.red       = 8'($urandom);
    it.green     = 8'($urandom);
    it.blue      = 8'($urandom);
    it.channel   = 2'($urandom);
    it.bin_index = 8'($urandom);
    // Narrow pools pile counts into a few bins so reads see values above one.
    case ($urandom_range(3))
      1: begin
        it.red   = 8'($urandom_range(7));
        it.green = 8'($urandom_range(7));
        it.blue  = 8'($urandom_range(7));
      end
      2: begin
        it.red   = 8'($urandom_range(255, 248));
        it.green = 8'($urandom_range(255, 248));
        it.blue  = 8'($urandom_range(255, 248));
      end
      default: ;
    endcase
    pick = $urandom_range(99);
    if (pick < 55) begin
      it.op = OP_ACCUM;
    end else if (pick < 90) begin
      it.op = OP_READ;
      if ($urandom_range(1) == 1) begin
        case (it.channel)
          CH_RED:   it.bin_index = last_red;
          CH_GREEN: it.bin_index = last_green;
          CH_BLUE:  it.bin_index = last_blue;
          default:  it.bin_index = last_luma;
        endcase
      end
    end else if (pick < 93) begin
      it.op = OP_CLEAR;
    end else begin
      it.op = OP_UNUSED;
    end
    return it;
  endfunction

  task automatic send_item(input in_item_t item, input logic typed, input out_item_t want);
    bit        makes_result;
    out_item_t predicted;
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      in_data  <= random_item();
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= item;
    do @(posedge clk); while (in_stall);
    apply_to_histograms(item, makes_result, predicted);
    if (makes_result) pending_bin_reads.push_back(typed ? want : predicted);
    transactions_sent++;
  endtask

  function automatic plan_row_t row(input logic [1:0] op, input logic [7:0] r,
                                    input logic [7:0] g, input logic [7:0] b,
                                    input logic [1:0] ch, input logic [7:0] idx,
                                    input logic typed, input logic [31:0] cnt,
                                    input logic [31:0] total);
    plan_row_t p;
    p.item  = '{op: op, red: r, green: g, blue: b, channel: ch, bin_index: idx};
    p.typed = typed;
    p.want  = '{bin_count: cnt, pixel_total: total};
    return p;
  endfunction

  // Receiver: random stall, or a long hold-off when one is requested.
  initial begin
    forever begin
      @(posedge clk);
      if (hold_req != hold_ack) begin
        hold_ack  = hold_req;
        hold_left = HOLD_LEN;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_stall <= 1'b1;
      end else begin
        out_stall <= ($urandom_range(99) < recv_stall_pct);
      end
    end
  end

  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall) begin
      if (pending_bin_reads.size() == 0) begin
        $error("result with no read pending: bin_count %0d pixel_total %0d",
               out_data.bin_count, out_data.pixel_total);
        failures++;
      end else begin
        seen_want = pending_bin_reads.pop_front();
        results_checked++;
        if (out_data.bin_count !== seen_want.bin_count) begin
          $error("bin_count: expected %0d, got %0d", seen_want.bin_count, out_data.bin_count);
          failures++;
        end
        if (out_data.pixel_total !== seen_want.pixel_total) begin
          $error("pixel_total: expected %0d, got %0d",
                 seen_want.pixel_total, out_data.pixel_total);
          failures++;
        end
      end
    end
  end

  always @(posedge clk) begin
    if (rst_n) begin
      if ((in_valid && !in_stall) || (out_valid && !out_stall)) begin
        quiet_cycles <= 0;
      end else if (quiet_cycles >= QUIET_MAX) begin
        $display("watchdog: no transaction for %0d cycles", quiet_cycles);
        $display("TB_ERROR");
        $finish;
      end else begin
        quiet_cycles <= quiet_cycles + 1;
      end
    end
  end

  initial begin
    int idle_plan [4];
    int stall_plan[4];
    idle_plan  = '{0, 62, 0, 21};
    stall_plan = '{0, 0, 62, 21};
    foreach (bin_seen[i]) begin
      bin_seen[i]  = '0;
      red_cnt[i]   = '0;
      green_cnt[i] = '0;
      blue_cnt[i]  = '0;
      luma_cnt[i]  = '0;
    end
    pixel_cnt  = '0;
    last_red   = '0;
    last_green = '0;
    last_blue  = '0;
    last_luma  = '0;

    // Reads of empty bins, extreme pixels, ignored fields, unused op, clear, repeat bins
    directed_rows.push_back(row(OP_READ,   8'd0,   8'd0,   8'd0,   CH_RED,   8'd0,   1, 0, 0));
    directed_rows.push_back(row(OP_READ,   8'd0,   8'd0,   8'd0,   CH_LUMA,  8'd255, 1, 0, 0));
    directed_rows.push_back(row(OP_ACCUM,  8'd255, 8'd255, 8'd255, CH_LUMA,  8'd255, 0, 0, 0));
    directed_rows.push_back(row(OP_ACCUM,  8'd0,   8'd0,   8'd0,   CH_RED,   8'd0,   0, 0, 0));
    directed_rows.push_back(row(OP_READ,   8'd0,   8'd0,   8'd0,   CH_RED,   8'd255, 1, 1, 2));
    directed_rows.push_back(row(OP_READ,   8'd0,   8'd0,   8'd0,   CH_LUMA,  8'd255, 1, 1, 2));
    directed_rows.push_back(row(OP_READ,   8'd0,   8'd0,   8'd0,   CH_LUMA,  8'd0,   1, 1, 2));
    directed_rows.push_back(row(OP_READ,   8'd0,   8'd0,   8'd0,   CH_GREEN, 8'd0,   1, 1, 2));
    directed_rows.push_back(row(OP_READ,   8'd255, 8'd255, 8'd255, CH_BLUE,  8'd128, 1, 0, 2));
    directed_rows.push_back(row(OP_ACCUM,  8'd255, 8'd0,   8'd255, CH_GREEN, 8'd170, 0, 0, 0));
    directed_rows.push_back(row(OP_READ,   8'd0,   8'd0,   8'd0,   CH_BLUE,  8'd255, 1, 2, 3));
    directed_rows.push_back(row(OP_UNUSED, 8'd255, 8'd255, 8'd255, CH_LUMA,  8'd255, 0, 0, 0));
    directed_rows.push_back(row(OP_READ,   8'd0,   8'd0,   8'd0,   CH_LUMA,  8'd73,  0, 0, 0));
    directed_rows.push_back(row(OP_READ,   8'd0,   8'd0,   8'd0,   CH_RED,   8'd255, 1, 2, 3));
    directed_rows.push_back(row(OP_CLEAR,  8'd255, 8'd255, 8'd255, CH_LUMA,  8'd255, 0, 0, 0));
    directed_rows.push_back(row(OP_READ,   8'd0,   8'd0,   8'd0,   CH_RED,   8'd255, 1, 0, 0));
    directed_rows.push_back(row(OP_READ,   8'd0,   8'd0,   8'd0,   CH_LUMA,  8'd0,   1, 0, 0));
    directed_rows.push_back(row(OP_ACCUM,  8'd1,   8'd2,   8'd3,   CH_RED,   8'd0,   0, 0, 0));
    directed_rows.push_back(row(OP_ACCUM,  8'd1,   8'd2,   8'd3,   CH_RED,   8'd0,   0, 0, 0));
    directed_rows.push_back(row(OP_ACCUM,  8'd1,   8'd2,   8'd3,   CH_RED,   8'd0,   0, 0, 0));
    directed_rows.push_back(row(OP_READ,   8'd0,   8'd0,   8'd0,   CH_RED,   8'd1,   1, 3, 3));
    directed_rows.push_back(row(OP_READ,   8'd0,   8'd0,   8'd0,   CH_LUMA,  8'd2,   0, 0, 0));
    directed_rows.push_back(row(OP_READ,   8'd0,   8'd0,   8'd0,   CH_GREEN, 8'd2,   0, 0, 0));

    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    foreach (directed_rows[i])
      send_item(directed_rows[i].item, directed_rows[i].typed, directed_rows[i].want);

    for (int phase = 0; phase < 4; phase++) begin
      send_idle_pct  = idle_plan[phase];
      recv_stall_pct = stall_plan[phase];
      repeat (PHASE_LEN) send_item(random_item(), 1'b0, '0);
      if (phase == 0) begin
        // Hold the result side while reads keep coming, so the block backs up.
        hold_req++;
        repeat (24) begin
          in_item_t rd;
          rd = random_item();
          rd.op = OP_READ;
          send_item(rd, 1'b0, '0);
        end
      end
    end
    in_valid       <= 1'b0;
    recv_stall_pct = 0;

    while (pending_bin_reads.size() != 0) @(posedge clk);
    repeat (DRAIN_WAIT) @(posedge clk);

    if (pending_bin_reads.size() != 0) begin
      $error("%0d reads never answered", pending_bin_reads.size());
      failures++;
    end
    $display("Sent %0d transactions across four stall/idle mixes and one long output hold;",
             transactions_sent);
    $display("checked %0d read results, %0d clears seen, %0d failures.",
             results_checked, clears_seen, failures);
    if (failures == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule
